[hw/rtl/tccw_pkg.sv]
// Shared types, constants and helper functions for the text console char writer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package tccw_pkg;

   localparam int SCREEN_WIDTH = 80;
   localparam int COL_BITS     = $clog2(SCREEN_WIDTH);
   localparam int CURSOR_BITS  = 16;
   localparam int NUM_BITS     = 64;
   localparam int BCD_DIGITS   = 20;
   localparam int BCD_BITS     = 4 * BCD_DIGITS;
   localparam int CNT_BITS     = 6;

   localparam logic [CNT_BITS-1:0] CONVERT_LAST = CNT_BITS'(NUM_BITS - 1);
   localparam logic [CNT_BITS-1:0] DIGITS_LAST  = CNT_BITS'(BCD_DIGITS - 1);
   localparam logic [COL_BITS-1:0] COL_LAST     = COL_BITS'(SCREEN_WIDTH - 1);

   localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE        = 8'h20;
   localparam logic [7:0] CHAR_MINUS        = 8'h2D;
   localparam logic [7:0] CHAR_ZERO         = 8'h30;
   localparam logic [7:0] CHAR_X            = 8'h78;
   localparam logic [7:0] SCAN_BACKSPACE    = 8'h8E;
   localparam logic [7:0] HEX_DIGIT_OFFSET  = 8'd48;
   localparam logic [7:0] HEX_ALPHA_OFFSET  = 8'd55;

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_KEY  = 2'd1,
      OP_DEC  = 2'd2,
      OP_HEX  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_CELL     = 2'd0,
      KIND_ROW_FILL = 2'd1,
      KIND_CURSOR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE   = 2'd0,
      SIZE_HALF   = 2'd1,
      SIZE_WORD   = 2'd2,
      SIZE_DOUBLE = 2'd3
   } size_type;

   typedef enum logic [2:0] {
      EMIT_CODE      = 3'd0,
      EMIT_ERASE     = 3'd1,
      EMIT_MINUS     = 3'd2,
      EMIT_DEC_DIGIT = 3'd3,
      EMIT_HEX_ZERO  = 3'd4,
      EMIT_HEX_X     = 3'd5,
      EMIT_HEX_DIGIT = 3'd6,
      EMIT_CURSOR    = 3'd7
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_CHAR       = 4'd1,
      ST_KEY        = 4'd2,
      ST_SIGN       = 4'd3,
      ST_CONVERT    = 4'd4,
      ST_DIGITS     = 4'd5,
      ST_HEX_ZERO   = 4'd6,
      ST_HEX_X      = 4'd7,
      ST_HEX_DIGITS = 4'd8,
      ST_CURSOR     = 4'd9
   } state_type;

   typedef struct packed {
      logic     load;
      logic     emit;
      emit_type sel;
      logic     newline;
      logic     dabble;
      logic     bcd_shift;
      logic     hex_shift;
      logic     start_digits;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_newline;
      logic bs_active;
      logic negative;
      logic cnt_zero;
      logic digit_show;
   } status_type;

   function automatic logic [NUM_BITS-1:0] size_mask(input logic [1:0] size);
      logic [NUM_BITS-1:0] m;
      unique case (size)
         SIZE_BYTE: m = 64'h0000_0000_0000_00FF;
         SIZE_HALF: m = 64'h0000_0000_0000_FFFF;
         SIZE_WORD: m = 64'h0000_0000_FFFF_FFFF;
         default:   m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic sign_bit(input logic [NUM_BITS-1:0] v, input logic [1:0] size);
      logic s;
      unique case (size)
         SIZE_BYTE: s = v[7];
         SIZE_HALF: s = v[15];
         SIZE_WORD: s = v[31];
         default:   s = v[63];
      endcase
      return s;
   endfunction

   function automatic logic [NUM_BITS-1:0] align_hex(input logic [NUM_BITS-1:0] v,
                                                    input logic [1:0] size);
      logic [NUM_BITS-1:0] a;
      unique case (size)
         SIZE_BYTE: a = {v[7:0], 56'b0};
         SIZE_HALF: a = {v[15:0], 48'b0};
         SIZE_WORD: a = {v[31:0], 32'b0};
         default:   a = v;
      endcase
      return a;
   endfunction

   function automatic logic [CNT_BITS-1:0] hex_last(input logic [1:0] size);
      logic [CNT_BITS-1:0] n;
      unique case (size)
         SIZE_BYTE: n = CNT_BITS'(1);
         SIZE_HALF: n = CNT_BITS'(3);
         SIZE_WORD: n = CNT_BITS'(7);
         default:   n = CNT_BITS'(15);
      endcase
      return n;
   endfunction

   function automatic logic [BCD_BITS-1:0] dabble_adjust(input logic [BCD_BITS-1:0] bcd);
      logic [BCD_BITS-1:0] r;
      logic [3:0]          d;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = bcd[4*i +: 4];
         r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      return (d > 4'd9) ? {4'b0, d} + HEX_ALPHA_OFFSET : {4'b0, d} + HEX_DIGIT_OFFSET;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tccw_req_if.sv]
// Request channel interface: valid/ready handshake with the operation payload.
// Depends on nothing but its own signal list.
`default_nettype none

interface tccw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  char_code;
   logic [63:0] number_bits;
   logic [1:0]  number_size;
   logic        number_is_signed;

   modport source (output valid, operation, char_code, number_bits, number_size,
                   number_is_signed, input ready);
   modport sink   (input valid, operation, char_code, number_bits, number_size,
                   number_is_signed, output ready);
endinterface

`default_nettype wire

[hw/rtl/tccw_rsp_if.sv]
// Response channel interface: valid/ready handshake with one display result.
// Depends on nothing but its own signal list.
`default_nettype none

interface tccw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] cell_index;
   logic [7:0]  cell_char;
   logic [15:0] new_cursor;
   logic        last_of_run;

   modport source (output valid, result_kind, cell_index, cell_char, new_cursor,
                   last_of_run, input ready);
   modport sink   (input valid, result_kind, cell_index, cell_char, new_cursor,
                   last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/tccw_datapath.sv]
// Datapath: cursor and column registers, number work registers, BCD converter,
// result register. Driven by commands from tccw_ctrl; uses tccw_pkg.
`default_nettype none

module tccw_datapath
   import tccw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [63:0] req_number_bits,
   input  logic [1:0]  req_number_size,
   input  logic        req_number_is_signed,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_cell_index,
   output logic [7:0]  rsp_cell_char,
   output logic [15:0] rsp_new_cursor,
   output logic        rsp_last_of_run
);

   localparam logic [CURSOR_BITS-1:0] WIDTH_CELLS = CURSOR_BITS'(SCREEN_WIDTH);

   logic [CURSOR_BITS-1:0] cursor_ff;
   logic [COL_BITS-1:0]    col_ff;
   logic [7:0]             code_ff;
   logic                   neg_ff;
   logic [NUM_BITS-1:0]    work_ff;
   logic [BCD_BITS-1:0]    bcd_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   started_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_kind_ff;
   logic [15:0]            rsp_cell_ff;
   logic [7:0]             rsp_char_ff;
   logic [15:0]            rsp_cursor_ff;
   logic                   rsp_last_ff;

   logic [NUM_BITS-1:0]    load_mask;
   logic [NUM_BITS-1:0]    load_value;
   logic                   load_neg;
   logic [NUM_BITS-1:0]    load_mag;

   logic [CURSOR_BITS-1:0] cursor_inc;
   logic [COL_BITS-1:0]    col_inc;
   logic [CURSOR_BITS:0]   nl_sum;
   logic [CURSOR_BITS-1:0] nl_cursor;
   logic [CURSOR_BITS-1:0] prev_row;
   logic [CURSOR_BITS-1:0] prev_cell;
   logic [BCD_BITS-1:0]    bcd_adj;

   logic [1:0]             emit_kind;
   logic [15:0]            emit_cell;
   logic [7:0]             emit_char;
   logic [15:0]            emit_newc;
   logic                   emit_last;
   logic [CURSOR_BITS-1:0] cursor_in;
   logic [COL_BITS-1:0]    col_in;

   assign load_mask  = size_mask(req_number_size);
   assign load_value = req_number_bits & load_mask;
   assign load_neg   = req_number_is_signed && sign_bit(load_value, req_number_size);
   assign load_mag   = load_neg ? ((~load_value + 64'd1) & load_mask) : load_value;

   assign cursor_inc = cursor_ff + 16'd1;
   assign col_inc    = (cursor_ff == '1 || col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
   assign nl_sum     = {1'b0, cursor_ff} + {1'b0, WIDTH_CELLS};
   assign nl_cursor  = nl_sum[CURSOR_BITS] ? '0
                       : nl_sum[CURSOR_BITS-1:0] - CURSOR_BITS'(col_ff);
   assign prev_row   = cursor_ff - WIDTH_CELLS;
   assign prev_cell  = cursor_ff - 16'd1;
   assign bcd_adj    = dabble_adjust(bcd_ff);

   always_comb begin
      emit_kind = KIND_CELL;
      emit_cell = cursor_ff;
      emit_char = code_ff;
      emit_newc = '0;
      emit_last = 1'b0;
      cursor_in = cursor_inc;
      col_in    = col_inc;
      unique case (cmd.sel)
         EMIT_CODE: begin
            emit_char = code_ff;
         end
         EMIT_ERASE: begin
            emit_char = CHAR_SPACE;
            if (col_ff == '0) begin
               emit_kind = KIND_ROW_FILL;
               emit_cell = prev_row;
               cursor_in = prev_row;
               col_in    = col_ff;
            end else begin
               emit_cell = prev_cell;
               cursor_in = prev_cell;
               col_in    = col_ff - 1'b1;
            end
         end
         EMIT_MINUS: begin
            emit_char = CHAR_MINUS;
         end
         EMIT_DEC_DIGIT: begin
            emit_char = CHAR_ZERO + {4'b0, bcd_ff[BCD_BITS-1 -: 4]};
         end
         EMIT_HEX_ZERO: begin
            emit_char = CHAR_ZERO;
         end
         EMIT_HEX_X: begin
            emit_char = CHAR_X;
         end
         EMIT_HEX_DIGIT: begin
            emit_char = hex_char(work_ff[NUM_BITS-1 -: 4]);
         end
         EMIT_CURSOR: begin
            emit_kind = KIND_CURSOR;
            emit_cell = '0;
            emit_char = '0;
            emit_newc = cursor_ff;
            emit_last = 1'b1;
            cursor_in = cursor_ff;
            col_in    = col_ff;
         end
         default: begin
            cursor_in = cursor_ff;
            col_in    = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
      end else if (cmd.emit) begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
      end else if (cmd.newline) begin
         cursor_ff <= nl_cursor;
         col_ff    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= req_char_code;
         neg_ff  <= load_neg;
         bcd_ff  <= '0;
         if (req_operation == OP_HEX) begin
            work_ff <= align_hex(load_value, req_number_size);
            cnt_ff  <= hex_last(req_number_size);
         end else begin
            work_ff <= load_mag;
            cnt_ff  <= CONVERT_LAST;
         end
      end else begin
         if (cmd.dabble) begin
            bcd_ff  <= {bcd_adj[BCD_BITS-2:0], work_ff[NUM_BITS-1]};
            work_ff <= {work_ff[NUM_BITS-2:0], 1'b0};
         end else if (cmd.bcd_shift) begin
            bcd_ff  <= {bcd_ff[BCD_BITS-5:0], 4'b0};
         end else if (cmd.hex_shift) begin
            work_ff <= {work_ff[NUM_BITS-5:0], 4'b0};
         end
         if (cmd.start_digits) begin
            cnt_ff <= DIGITS_LAST;
         end else if (cmd.dabble || cmd.bcd_shift || cmd.hex_shift) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (cmd.load || cmd.start_digits) begin
         started_ff <= 1'b0;
      end else if (cmd.emit && cmd.sel == EMIT_DEC_DIGIT) begin
         started_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_cell_ff   <= emit_cell;
         rsp_char_ff   <= emit_char;
         rsp_cursor_ff <= emit_newc;
         rsp_last_ff   <= emit_last;
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.is_newline = (code_ff == CHAR_NEWLINE);
   assign status.bs_active  = (code_ff == SCAN_BACKSPACE) && (cursor_ff != '0);
   assign status.negative   = neg_ff;
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.digit_show = (bcd_ff[BCD_BITS-1 -: 4] != 4'd0) || started_ff
                              || (cnt_ff == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_cell_index  = rsp_cell_ff;
   assign rsp_cell_char   = rsp_char_ff;
   assign rsp_new_cursor  = rsp_cursor_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_LAST)
      else $error("column register out of range");

   a_col_home: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == '0 |-> col_ff == '0)
      else $error("cursor at cell zero with nonzero column");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result register overwritten while pending");

   a_last_is_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_kind_ff == KIND_CURSOR)
      else $error("final result of a transaction is not a cursor update");

endmodule

`default_nettype wire

[hw/rtl/tccw_ctrl.sv]
// Controller state machine: sequences each operation and issues datapath commands.
// Uses tccw_pkg for state, command and status types.
`default_nettype none

module tccw_ctrl
   import tccw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_operation,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_CHAR: state_in = ST_CHAR;
                  OP_KEY:  state_in = ST_KEY;
                  OP_DEC:  state_in = ST_SIGN;
                  default: state_in = ST_HEX_ZERO;
               endcase
            end
         end
         ST_CHAR: begin
            if (status.is_newline || status.out_free) state_in = ST_CURSOR;
         end
         ST_KEY: begin
            if (!status.bs_active || status.out_free) state_in = ST_CURSOR;
         end
         ST_SIGN: begin
            if (!status.negative || status.out_free) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.cnt_zero) state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (status.cnt_zero && status.out_free) state_in = ST_CURSOR;
         end
         ST_HEX_ZERO: begin
            if (status.out_free) state_in = ST_HEX_X;
         end
         ST_HEX_X: begin
            if (status.out_free) state_in = ST_HEX_DIGITS;
         end
         ST_HEX_DIGITS: begin
            if (status.cnt_zero && status.out_free) state_in = ST_CURSOR;
         end
         ST_CURSOR: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHAR: begin
            cmd.sel = EMIT_CODE;
            if (status.is_newline) begin
               cmd.newline = 1'b1;
            end else begin
               cmd.emit = status.out_free;
            end
         end
         ST_KEY: begin
            cmd.sel  = EMIT_ERASE;
            cmd.emit = status.bs_active && status.out_free;
         end
         ST_SIGN: begin
            cmd.sel  = EMIT_MINUS;
            cmd.emit = status.negative && status.out_free;
         end
         ST_CONVERT: begin
            cmd.dabble       = 1'b1;
            cmd.start_digits = status.cnt_zero;
         end
         ST_DIGITS: begin
            cmd.sel = EMIT_DEC_DIGIT;
            if (status.digit_show) begin
               cmd.emit      = status.out_free;
               cmd.bcd_shift = status.out_free;
            end else begin
               cmd.bcd_shift = 1'b1;
            end
         end
         ST_HEX_ZERO: begin
            cmd.sel  = EMIT_HEX_ZERO;
            cmd.emit = status.out_free;
         end
         ST_HEX_X: begin
            cmd.sel  = EMIT_HEX_X;
            cmd.emit = status.out_free;
         end
         ST_HEX_DIGITS: begin
            cmd.sel       = EMIT_HEX_DIGIT;
            cmd.emit      = status.out_free;
            cmd.hex_shift = status.out_free;
         end
         ST_CURSOR: begin
            cmd.sel  = EMIT_CURSOR;
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !req_valid |=> state_ff == ST_IDLE)
      else $error("left idle without an accepted transaction");

endmodule

`default_nettype wire

[hw/rtl/text_console_char_writer_unit.sv]
// Text console char writer, top level: joins tccw_ctrl and tccw_datapath to the
// request and response channel interfaces. Uses tccw_pkg, tccw_req_if, tccw_rsp_if.
//
// Usage: a request transaction on req_chan carries one operation (character,
// special key scan code, decimal number, hex number). The block answers with a
// run of response transactions on rsp_chan (cell writes, row fills) that always
// ends with one cursor update flagged by last_of_run. A 16-bit cursor cell index
// and its column within an 80-cell row are kept between requests.
// A decimal number goes through a 64-step shift-and-add-3 binary-to-BCD loop
// followed by a 20-step digit scan; a hex number is written as 0x and then
// its digits (2 to 16).
// One request is worked on at a time; ready is high only when the controller
// is idle, and the next request can be taken while the final cursor update
// still waits in the result register.
// Reset clears the cursor to cell zero and drops any pending result. When the
// receiver holds ready low, the result register holds its transaction and the
// controller waits before producing the next one; nothing is lost.
`default_nettype none

module text_console_char_writer_unit
   import tccw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tccw_req_if.sink   req_chan,
   tccw_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic       ready;

   tccw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (ready),
      .status        (status),
      .cmd           (cmd)
   );

   tccw_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_operation        (req_chan.operation),
      .req_char_code        (req_chan.char_code),
      .req_number_bits      (req_chan.number_bits),
      .req_number_size      (req_chan.number_size),
      .req_number_is_signed (req_chan.number_is_signed),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_result_kind      (rsp_chan.result_kind),
      .rsp_cell_index       (rsp_chan.cell_index),
      .rsp_cell_char        (rsp_chan.cell_char),
      .rsp_new_cursor       (rsp_chan.new_cursor),
      .rsp_last_of_run      (rsp_chan.last_of_run)
   );

   assign req_chan.ready = ready;

endmodule

`default_nettype wire
